### rtl/odometry_gps_pose_fuser_defines.svh
// ----------------------------------------------------------------------------
// Odometry / GPS pose fuser assertion macros
// Clocked property checks that vanish when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ODOMETRY_GPS_POSE_FUSER_DEFINES_SVH
`define ODOMETRY_GPS_POSE_FUSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check a property on every rising clock edge, off during reset
`define OGPF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising clock edge, also during reset
`define OGPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define OGPF_ASSERT(lbl, clk, rst, prop, msg)
`define OGPF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/ogpf_pkg.sv
// ----------------------------------------------------------------------------
// Odometry / GPS pose fuser package
// Register indexes, field widths and reset values shared by the fuser files.
// ----------------------------------------------------------------------------
package ogpf_pkg;

   // control register port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOOP_PERIOD_MS     = 3'd0,
      CSR_DISTANCE_GAIN      = 3'd1,
      CSR_COURSE_YAW_GAIN    = 3'd2,
      CSR_ANTENNA_YAW_GAIN   = 3'd3,
      CSR_MAX_DISTANCE_ERROR = 3'd4,
      CSR_MAX_YAW_CORRECTION = 3'd5,
      CSR_GPS_YAW_NEGATE     = 3'd6
   } csr_index_type;

   // GPS yaw source codes; the high bit alone selects the antenna gain
   localparam logic [1:0] YAW_SRC_NONE         = 2'd0;
   localparam logic [1:0] YAW_SRC_COURSE       = 2'd1;
   localparam logic [1:0] YAW_SRC_ANTENNA      = 2'd2;
   localparam int unsigned YAW_SRC_ANTENNA_BIT = 1;

   // register reset values
   localparam logic [9:0]  LOOP_PERIOD_MS_RST     = 10'd10;
   localparam logic [15:0] DISTANCE_GAIN_RST      = 16'd1311;
   localparam logic [15:0] COURSE_YAW_GAIN_RST    = 16'd655;
   localparam logic [15:0] ANTENNA_YAW_GAIN_RST   = 16'd2621;
   localparam logic [30:0] MAX_DISTANCE_ERROR_RST = 31'd131072;
   localparam logic [30:0] MAX_YAW_CORRECTION_RST = 31'd298261618;

   // half an LSB of a Q16.16 result, added before the shift
   localparam logic signed [49:0] ROUND_HALF = 50'sd32768;

endpackage

### rtl/ogpf_if.sv
// ----------------------------------------------------------------------------
// Odometry / GPS pose fuser channels
// Valid/ready channels for ticks, fused results and register writes.
// ----------------------------------------------------------------------------

// one control tick
interface ogpf_req_if;
   logic               valid;
   logic               ready;
   logic               hold_level;
   logic               resync_request;
   logic signed [31:0] odo_dist;
   logic signed [31:0] odom_x;
   logic signed [31:0] odom_y;
   logic signed [31:0] odo_heading;
   logic signed [31:0] odom_speed;
   logic               gps_ok;
   logic        [31:0] gps_sequence;
   logic signed [31:0] gps_path;
   logic        [1:0]  gps_yaw_source;
   logic signed [31:0] gps_yaw;

   modport source (
      output valid, hold_level, resync_request, odo_dist, odom_x, odom_y,
             odo_heading, odom_speed, gps_ok, gps_sequence, gps_path,
             gps_yaw_source, gps_yaw,
      input  ready
   );
   modport sink (
      input  valid, hold_level, resync_request, odo_dist, odom_x, odom_y,
             odo_heading, odom_speed, gps_ok, gps_sequence, gps_path,
             gps_yaw_source, gps_yaw,
      output ready
   );
endinterface

// one fused pose
interface ogpf_rsp_if;
   logic               valid;
   logic               ready;
   logic        [31:0] elapsed_ms;
   logic signed [31:0] fused_yaw;
   logic signed [31:0] fused_x;
   logic signed [31:0] fused_y;
   logic signed [31:0] fused_dist;
   logic signed [31:0] speed_out;

   modport source (
      output valid, elapsed_ms, fused_yaw, fused_x, fused_y, fused_dist,
             speed_out,
      input  ready
   );
   modport sink (
      input  valid, elapsed_ms, fused_yaw, fused_x, fused_y, fused_dist,
             speed_out,
      output ready
   );
endinterface

// register write
interface ogpf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ogpf_pkg::CSR_INDEX_W-1:0]    index;
   logic [ogpf_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/odometry_gps_pose_fuser.sv
// ----------------------------------------------------------------------------
// Odometry / GPS pose fuser
// Integrates odometry into distance and x/y, anchors and nudges them by GPS.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one control tick per beat: odometry, hold/resync and the
//   latest GPS sample. rsp_if returns one fused pose per tick, in order.
//   csr_if writes the seven tuning registers; it is always ready. The user
//   must see it written only while no tick is in flight; the block does not enforce this.
// Datapath and throughput:
//   A tick lands in the input register, then one pass of adders, one
//   17x32 multiply per correction and a clamp updates the pose state and
//   the result register, from which rsp_if presents it.
//   One tick is taken every cycle while rsp_if.ready is high; the rate is
//   set by the state feedback loop through that single pass.
// Reset:
//   Synchronous, active high. Registers return to their defaults, the pose
//   and anchors clear and the next tick initialises from odometry.
// Stall:
//   While rsp_if.ready is low the result holds; one more tick waits in the
//   input register, after which req_if.ready drops.
// ----------------------------------------------------------------------------
`include "odometry_gps_pose_fuser_defines.svh"

module odometry_gps_pose_fuser (
   input  logic           clock,
   input  logic           reset,
   ogpf_req_if.sink       req_if,
   ogpf_rsp_if.source     rsp_if,
   ogpf_csr_if.sink       csr_if
);

   // tuning registers
   logic [9:0]  loop_period_ff;
   logic [15:0] dist_gain_ff;
   logic [15:0] course_gain_ff;
   logic [15:0] antenna_gain_ff;
   logic [30:0] max_dist_err_ff;
   logic [30:0] max_yaw_corr_ff;
   logic        yaw_negate_ff;

   // input stage
   logic        in_vld_ff;
   logic        in_hold_ff;
   logic        in_resync_ff;
   logic [31:0] in_odo_dist_ff;
   logic [31:0] in_odom_x_ff;
   logic [31:0] in_odom_y_ff;
   logic [31:0] in_odo_heading_ff;
   logic [31:0] in_odom_speed_ff;
   logic        in_gps_ok_ff;
   logic [31:0] in_gps_sequence_ff;
   logic [31:0] in_gps_path_ff;
   logic [1:0]  in_gps_yaw_source_ff;
   logic [31:0] in_gps_yaw_ff;

   // pose state; a pending resync is consumed within the same beat
   logic        started_ff;
   logic        hold_state_ff;
   logic [31:0] prev_dist_ff, prev_dist_in;
   logic [31:0] prev_x_ff, prev_x_in;
   logic [31:0] prev_y_ff, prev_y_in;
   logic [31:0] pos_x_ff, pos_x_in;
   logic [31:0] pos_y_ff, pos_y_in;
   logic [31:0] dist_acc_ff, dist_acc_in;
   logic        dist_anch_ff, dist_anch_in;
   logic [31:0] dist_offset_ff, dist_offset_in;
   logic        yaw_anch_ff, yaw_anch_in;
   logic [31:0] yaw_offset_ff, yaw_offset_in;
   logic [31:0] yaw_corr_ff, yaw_corr_in;
   logic [31:0] prev_seq_ff, prev_seq_in;
   logic [31:0] ms_ff, ms_in;

   // result stage
   logic        out_vld_ff;
   logic [31:0] out_elapsed_ff;
   logic [31:0] out_yaw_ff;
   logic [31:0] out_x_ff;
   logic [31:0] out_y_ff;
   logic [31:0] out_dist_ff;
   logic [31:0] out_speed_ff;

   // datapath
   logic               advance;
   logic               pending;
   logic [31:0]        dist_odo;
   logic               anch_odo;
   logic               seq_back;
   logic               seq_fresh;
   logic               dist_anch_b;
   logic               yaw_anch_b;
   logic [31:0]        yaw_corr_b;
   logic signed [31:0] dist_err;
   logic signed [32:0] dist_err_x;
   logic signed [32:0] dist_lim;
   logic               dist_in_range;
   logic signed [48:0] dist_prod;
   logic signed [49:0] dist_round;
   logic [31:0]        dist_step;
   logic [31:0]        gps_yaw_used;
   logic [15:0]        heading_gain;
   logic signed [31:0] yaw_err;
   logic signed [48:0] yaw_prod;
   logic signed [49:0] yaw_round;
   logic [31:0]        yaw_sum;
   logic signed [32:0] yaw_sum_x;
   logic signed [32:0] yaw_lim;
   logic [31:0]        yaw_clamped;

   // move a beat from the input register to the result register
   assign advance      = in_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_if.ready = !in_vld_ff || advance;
   assign csr_if.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_period_ff  <= ogpf_pkg::LOOP_PERIOD_MS_RST;
         dist_gain_ff    <= ogpf_pkg::DISTANCE_GAIN_RST;
         course_gain_ff  <= ogpf_pkg::COURSE_YAW_GAIN_RST;
         antenna_gain_ff <= ogpf_pkg::ANTENNA_YAW_GAIN_RST;
         max_dist_err_ff <= ogpf_pkg::MAX_DISTANCE_ERROR_RST;
         max_yaw_corr_ff <= ogpf_pkg::MAX_YAW_CORRECTION_RST;
         yaw_negate_ff   <= 1'b0;
      end else if (csr_if.valid) begin
         unique case (ogpf_pkg::csr_index_type'(csr_if.index))
            ogpf_pkg::CSR_LOOP_PERIOD_MS:     loop_period_ff  <= csr_if.data[9:0];
            ogpf_pkg::CSR_DISTANCE_GAIN:      dist_gain_ff    <= csr_if.data[15:0];
            ogpf_pkg::CSR_COURSE_YAW_GAIN:    course_gain_ff  <= csr_if.data[15:0];
            ogpf_pkg::CSR_ANTENNA_YAW_GAIN:   antenna_gain_ff <= csr_if.data[15:0];
            ogpf_pkg::CSR_MAX_DISTANCE_ERROR: max_dist_err_ff <= csr_if.data[30:0];
            ogpf_pkg::CSR_MAX_YAW_CORRECTION: max_yaw_corr_ff <= csr_if.data[30:0];
            ogpf_pkg::CSR_GPS_YAW_NEGATE:     yaw_negate_ff   <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   // capture the tick
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_hold_ff           <= req_if.hold_level;
         in_resync_ff         <= req_if.resync_request;
         in_odo_dist_ff       <= req_if.odo_dist;
         in_odom_x_ff         <= req_if.odom_x;
         in_odom_y_ff         <= req_if.odom_y;
         in_odo_heading_ff    <= req_if.odo_heading;
         in_odom_speed_ff     <= req_if.odom_speed;
         in_gps_ok_ff         <= req_if.gps_ok;
         in_gps_sequence_ff   <= req_if.gps_sequence;
         in_gps_path_ff       <= req_if.gps_path;
         in_gps_yaw_source_ff <= req_if.gps_yaw_source;
         in_gps_yaw_ff        <= req_if.gps_yaw;
      end
   end

   // odometry: initialise, rebase or integrate
   always_comb begin
      pending  = in_resync_ff || (in_hold_ff != hold_state_ff);
      ms_in    = ms_ff + {22'd0, loop_period_ff};
      dist_odo = dist_acc_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      anch_odo = dist_anch_ff;
      if (!started_ff) begin
         dist_odo = in_odo_dist_ff;
         pos_x_in = in_odom_x_ff;
         pos_y_in = in_odom_y_ff;
      end else if (pending) begin
         anch_odo = 1'b0;
      end else if (!in_hold_ff) begin
         dist_odo = dist_acc_ff + (in_odo_dist_ff - prev_dist_ff);
         pos_x_in = pos_x_ff + (in_odom_x_ff - prev_x_ff);
         pos_y_in = pos_y_ff + (in_odom_y_ff - prev_y_ff);
      end
      prev_dist_in = in_odo_dist_ff;
      prev_x_in    = in_odom_x_ff;
      prev_y_in    = in_odom_y_ff;
   end

   // sequence check; a backward sequence drops both anchors
   assign seq_back    = in_gps_sequence_ff < prev_seq_ff;
   assign seq_fresh   = in_gps_sequence_ff != prev_seq_ff;
   assign dist_anch_b = anch_odo && !seq_back;
   assign yaw_anch_b  = yaw_anch_ff && !seq_back;
   assign yaw_corr_b  = seq_back ? 32'd0 : yaw_corr_ff;

   // distance correction: gain times error, rounded half up to Q16.16
   assign dist_err      = $signed(in_gps_path_ff + dist_offset_ff - dist_odo);
   assign dist_err_x    = {dist_err[31], dist_err};
   assign dist_lim      = $signed({2'b00, max_dist_err_ff});
   assign dist_in_range = (dist_err_x < dist_lim) && (dist_err_x > -dist_lim);
   assign dist_prod     = $signed({1'b0, dist_gain_ff}) * dist_err;
   assign dist_round    = {dist_prod[48], dist_prod} + ogpf_pkg::ROUND_HALF;
   assign dist_step     = dist_round[47:16];

   // yaw correction: same rounding, then wrap and clamp
   assign gps_yaw_used = yaw_negate_ff ? (32'd0 - in_gps_yaw_ff) : in_gps_yaw_ff;
   assign heading_gain = in_gps_yaw_source_ff[ogpf_pkg::YAW_SRC_ANTENNA_BIT] ?
                         antenna_gain_ff : course_gain_ff;
   assign yaw_err      = $signed(gps_yaw_used + yaw_offset_ff - in_odo_heading_ff);
   assign yaw_prod     = $signed({1'b0, heading_gain}) * yaw_err;
   assign yaw_round    = {yaw_prod[48], yaw_prod} + ogpf_pkg::ROUND_HALF;
   assign yaw_sum      = yaw_corr_b + yaw_round[47:16];
   assign yaw_sum_x    = {yaw_sum[31], yaw_sum};
   assign yaw_lim      = $signed({2'b00, max_yaw_corr_ff});

   always_comb begin
      if (yaw_sum_x > yaw_lim) begin
         yaw_clamped = yaw_lim[31:0];
      end else if (yaw_sum_x < -yaw_lim) begin
         yaw_clamped = 32'd0 - yaw_lim[31:0];
      end else begin
         yaw_clamped = yaw_sum;
      end
   end

   // GPS: on hold drop the distance anchor, else anchor, then nudge distance and yaw on a fresh sample
   always_comb begin
      dist_acc_in    = dist_odo;
      dist_anch_in   = anch_odo;
      dist_offset_in = dist_offset_ff;
      yaw_anch_in    = yaw_anch_ff;
      yaw_offset_in  = yaw_offset_ff;
      yaw_corr_in    = yaw_corr_ff;
      prev_seq_in    = prev_seq_ff;
      if (in_hold_ff) begin
         dist_anch_in = 1'b0;
      end else if (in_gps_ok_ff && seq_fresh) begin
         dist_anch_in = 1'b1;
         yaw_anch_in  = yaw_anch_b;
         yaw_corr_in  = yaw_corr_b;
         prev_seq_in  = in_gps_sequence_ff;
         if (!dist_anch_b) begin
            dist_offset_in = dist_odo - in_gps_path_ff;
         end else if (dist_in_range) begin
            dist_acc_in = dist_odo + dist_step;
         end
         if (in_gps_yaw_source_ff != ogpf_pkg::YAW_SRC_NONE) begin
            if (!yaw_anch_b) begin
               yaw_offset_in = in_odo_heading_ff - gps_yaw_used;
               yaw_anch_in   = 1'b1;
            end else begin
               yaw_corr_in = yaw_clamped;
            end
         end
      end
   end

   // commit the pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         hold_state_ff  <= 1'b0;
         prev_dist_ff   <= 32'd0;
         prev_x_ff      <= 32'd0;
         prev_y_ff      <= 32'd0;
         pos_x_ff       <= 32'd0;
         pos_y_ff       <= 32'd0;
         dist_acc_ff    <= 32'd0;
         dist_anch_ff   <= 1'b0;
         dist_offset_ff <= 32'd0;
         yaw_anch_ff    <= 1'b0;
         yaw_offset_ff  <= 32'd0;
         yaw_corr_ff    <= 32'd0;
         prev_seq_ff    <= 32'd0;
         ms_ff          <= 32'd0;
      end else if (advance) begin
         started_ff     <= 1'b1;
         hold_state_ff  <= in_hold_ff;
         prev_dist_ff   <= prev_dist_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         dist_acc_ff    <= dist_acc_in;
         dist_anch_ff   <= dist_anch_in;
         dist_offset_ff <= dist_offset_in;
         yaw_anch_ff    <= yaw_anch_in;
         yaw_offset_ff  <= yaw_offset_in;
         yaw_corr_ff    <= yaw_corr_in;
         prev_seq_ff    <= prev_seq_in;
         ms_ff          <= ms_in;
      end
   end

   // hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_elapsed_ff <= ms_in;
         out_yaw_ff     <= in_odo_heading_ff + yaw_corr_in;
         out_x_ff       <= pos_x_in;
         out_y_ff       <= pos_y_in;
         out_dist_ff    <= dist_acc_in;
         out_speed_ff   <= in_odom_speed_ff;
      end
   end

   assign rsp_if.valid      = out_vld_ff;
   assign rsp_if.elapsed_ms = out_elapsed_ff;
   assign rsp_if.fused_yaw  = out_yaw_ff;
   assign rsp_if.fused_x    = out_x_ff;
   assign rsp_if.fused_y    = out_y_ff;
   assign rsp_if.fused_dist = out_dist_ff;
   assign rsp_if.speed_out  = out_speed_ff;

   // checks
   `OGPF_ASSERT(a_ms_step, clock, reset, advance |=> (ms_ff == $past(ms_in)), "period not added")
   `OGPF_ASSERT(a_hold, clock, reset, (advance && in_hold_ff) |=> !dist_anch_ff, "anchor kept")
   `OGPF_ASSERT_ALWAYS(a_start, clock, (dist_anch_ff || yaw_anch_ff) |-> started_ff, "no start")

endmodule
